/* sv/scharr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scharr_pkg
// Shared types and constants of the 3x3 Scharr gradient block.
// ----------------------------------------------------------------------------
package scharr_pkg;

  // configuration port
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned WidthRegW  = 11;
  localparam int unsigned HeightRegW = 13;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;

  localparam logic [WidthRegW-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightRegW-1:0] HeightReset = 13'd480;

  // row counter covers the tallest frame
  localparam int unsigned RowW      = 12;
  localparam int unsigned MaxHeight = 4096;

  // result kinds of one sample, in emission order (bit positions of a mask)
  localparam int unsigned NumKinds     = 4;
  localparam int unsigned KindUpLeft   = 0;  // row above, column to the left
  localparam int unsigned KindLowLeft  = 1;  // last row, column to the left
  localparam int unsigned KindUpRight  = 2;  // row above, last column
  localparam int unsigned KindLowRight = 3;  // last row, last column

  typedef logic [NumKinds-1:0] kind_mask_t;

endpackage

/* sv/scharr_gradient_3x3.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scharr_gradient_3x3
// Streaming 3x3 Scharr gradient (weights 3, 10, 3) with reflect padding.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter in raster order on the in_valid_i / in_ready_o channel.
//   Gradient results leave on out_valid_o / out_ready_i, one per request,
//   tagged with row and column; results lag the input by one row and one
//   pixel. grad_x_o and grad_y_o hold 32 times the gradient, unrounded.
//   Image size is set on the cfg channel (index 0 width, 1 height); a write
//   to either restarts the frame. Write only while the block is idle.
// Timing:
//   A result passes the input stage, window stage and output register after
//   the sample that causes it is accepted. One shared gradient unit gives one
//   result per cycle while the receiver keeps up, so a sample is taken every
//   cycle unless it causes two results (the last sample of every row after the
//   first, every sample past column 0 on the last row) or four (frame end).
// Reset:
//   Counters clear, size returns to 640 x 480. The line memory is not
//   cleared; the first rows never use its old contents.
// Stall:
//   A stalled receiver holds the output register; the gradient stage and
//   the input stage fill behind it, and then in_ready_o drops.
// ----------------------------------------------------------------------------
module scharr_gradient_3x3
  import scharr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CfgIdxW-1:0]            cfg_index_i,
  input  logic [CfgDataW-1:0]           cfg_data_i,
  // sample stream
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  // gradient stream
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [RowW-1:0]               row_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  column_o,
  output logic signed [SAMPLE_BITS+4:0] grad_x_o,
  output logic signed [SAMPLE_BITS+4:0] grad_y_o,
  output logic                          run_end_o,
  output logic                          frame_end_o
);

  localparam int unsigned ColW   = $clog2(MAX_WIDTH);
  localparam int unsigned GuardW = 5;
  localparam int unsigned GradW  = SAMPLE_BITS + GuardW;
  localparam int unsigned PairW  = 2 * SAMPLE_BITS;

  // --------------------------------------------------------------------------
  // configuration and position counters
  // --------------------------------------------------------------------------
  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic [CfgDataW-1:0]   eff_w, eff_h;
  logic [ColW-1:0]       last_col;
  logic [RowW-1:0]       last_row;
  logic [ColW-1:0]       pix_col_q;
  logic [RowW-1:0]       pix_row_q;
  logic                  in_accept;
  logic                  cfg_hit;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (CfgDataW'(width_q) < CfgDataW'(2)) begin
      eff_w = CfgDataW'(2);
    end else if (CfgDataW'(width_q) > CfgDataW'(MAX_WIDTH)) begin
      eff_w = CfgDataW'(MAX_WIDTH);
    end else begin
      eff_w = CfgDataW'(width_q);
    end
    if (height_q < CfgDataW'(2)) begin
      eff_h = CfgDataW'(2);
    end else if (height_q > CfgDataW'(MaxHeight)) begin
      eff_h = CfgDataW'(MaxHeight);
    end else begin
      eff_h = height_q;
    end
    last_col = ColW'(eff_w - CfgDataW'(1));
    last_row = RowW'(eff_h - CfgDataW'(1));
  end

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegImageWidth:  cfg_hit = 1'b1;
        RegImageHeight: cfg_hit = 1'b1;
        default:        cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WidthReset;
      height_q  <= HeightReset;
      pix_col_q <= '0;
      pix_row_q <= '0;
    end else if (cfg_hit) begin
      // restart the frame on any register write
      if (cfg_index_i == RegImageWidth) begin
        width_q <= cfg_data_i[WidthRegW-1:0];
      end else begin
        height_q <= cfg_data_i;
      end
      pix_col_q <= '0;
      pix_row_q <= '0;
    end else if (in_accept) begin
      if (pix_col_q == last_col) begin
        pix_col_q <= '0;
        pix_row_q <= (pix_row_q == last_row) ? '0 : pix_row_q + RowW'(1);
      end else begin
        pix_col_q <= pix_col_q + ColW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // input stage: sample, line memory read, result kinds
  // --------------------------------------------------------------------------
  logic [PairW-1:0]              line_mem [MAX_WIDTH];
  logic [PairW-1:0]              a_rd_q;
  logic                          a_vld_q;
  logic signed [SAMPLE_BITS-1:0] a_sample_q;
  logic [ColW-1:0]               a_col_q;
  logic [RowW-1:0]               a_row_q;
  logic                          a_top_q, a_left_q;
  kind_mask_t                    a_mask_q;
  kind_mask_t                    mask_d;
  logic                          a_adv;
  logic                          up_ok, on_last_row;

  always_comb begin
    up_ok       = (pix_row_q != '0);
    on_last_row = (pix_row_q == last_row);
    mask_d                = '0;
    mask_d[KindUpLeft]    = up_ok && (pix_col_q != '0);
    mask_d[KindLowLeft]   = up_ok && (pix_col_q != '0) && on_last_row;
    mask_d[KindUpRight]   = up_ok && (pix_col_q == last_col);
    mask_d[KindLowRight]  = up_ok && (pix_col_q == last_col) && on_last_row;
  end

  assign in_accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (in_accept) begin
      a_vld_q <= 1'b1;
    end else if (a_adv) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_sample_q <= sample_i;
      a_col_q    <= pix_col_q;
      a_row_q    <= pix_row_q;
      a_top_q    <= (pix_row_q == RowW'(1));
      a_left_q   <= (pix_col_q == ColW'(1));
      a_mask_q   <= mask_d;
    end
  end

  // each entry holds {row two above, row above}; shift it when the column moves on
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_rd_q <= line_mem[pix_col_q];
    end
    if (a_adv) begin
      line_mem[a_col_q] <= {a_rd_q[SAMPLE_BITS-1:0], a_sample_q};
    end
  end

  // --------------------------------------------------------------------------
  // window stage: 3x3 window and result sequencing
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] win_q [3][3];
  kind_mask_t                    b_mask_q;
  kind_mask_t                    sel;
  logic [ColW-1:0]               b_col_q;
  logic [RowW-1:0]               b_row_q;
  logic                          b_top_q, b_left_q;
  logic                          b_go, b_last, b_done;
  logic                          out_vld_q;

  assign sel    = b_mask_q & kind_mask_t'(~b_mask_q + kind_mask_t'(1));
  assign b_last = ((b_mask_q & ~sel) == '0);
  assign b_go   = (b_mask_q != '0) && (!out_vld_q || out_ready_i);
  assign b_done = b_go && b_last;
  assign a_adv  = a_vld_q && ((b_mask_q == '0) || b_done);

  assign in_ready_o = (!a_vld_q || a_adv) && !cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_mask_q <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (a_adv) begin
      b_mask_q <= a_mask_q;
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= a_rd_q[PairW-1:SAMPLE_BITS];
      win_q[1][2] <= a_rd_q[SAMPLE_BITS-1:0];
      win_q[2][2] <= a_sample_q;
    end else if (b_go) begin
      b_mask_q <= b_mask_q & ~sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_col_q  <= a_col_q;
      b_row_q  <= a_row_q;
      b_top_q  <= a_top_q;
      b_left_q <= a_left_q;
    end
  end

  // --------------------------------------------------------------------------
  // gradient unit
  // --------------------------------------------------------------------------
  function automatic logic signed [GradW-1:0] ext(input logic signed [SAMPLE_BITS-1:0] v);
    return {{GuardW{v[SAMPLE_BITS-1]}}, v};
  endfunction

  function automatic logic signed [GradW-1:0] x3(input logic signed [GradW-1:0] d);
    return (d <<< 1) + d;
  endfunction

  function automatic logic signed [GradW-1:0] x10(input logic signed [GradW-1:0] d);
    return (d <<< 3) + (d <<< 1);
  endfunction

  logic signed [SAMPLE_BITS-1:0] top_v [3];
  logic signed [SAMPLE_BITS-1:0] mid_v [3];
  logic signed [SAMPLE_BITS-1:0] bot_v [3];
  logic signed [SAMPLE_BITS-1:0] t_l, t_c, t_r, m_l, m_r, b_l, b_c, b_r;
  logic signed [GradW-1:0]       gx, gy;
  logic                          low_kind, edge_kind;

  always_comb begin
    low_kind  = sel[KindLowLeft] || sel[KindLowRight];
    edge_kind = sel[KindUpRight] || sel[KindLowRight];
    // last row mirrors the row above; the first output row mirrors row 1
    for (int j = 0; j < 3; j++) begin
      top_v[j] = low_kind ? win_q[1][j] : (b_top_q ? win_q[2][j] : win_q[0][j]);
      mid_v[j] = low_kind ? win_q[2][j] : win_q[1][j];
      bot_v[j] = low_kind ? win_q[1][j] : win_q[2][j];
    end
    // last column mirrors its left neighbor; column 0 mirrors column 1
    t_l = edge_kind ? top_v[1] : (b_left_q ? top_v[2] : top_v[0]);
    t_c = edge_kind ? top_v[2] : top_v[1];
    t_r = edge_kind ? top_v[1] : top_v[2];
    m_l = edge_kind ? mid_v[1] : (b_left_q ? mid_v[2] : mid_v[0]);
    m_r = edge_kind ? mid_v[1] : mid_v[2];
    b_l = edge_kind ? bot_v[1] : (b_left_q ? bot_v[2] : bot_v[0]);
    b_c = edge_kind ? bot_v[2] : bot_v[1];
    b_r = edge_kind ? bot_v[1] : bot_v[2];
    gx = x3(ext(t_r) - ext(t_l)) + x10(ext(m_r) - ext(m_l)) + x3(ext(b_r) - ext(b_l));
    gy = x3(ext(b_l) - ext(t_l)) + x10(ext(b_c) - ext(t_c)) + x3(ext(b_r) - ext(t_r));
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic [RowW-1:0]         o_row_q;
  logic [ColW-1:0]         o_col_q;
  logic signed [GradW-1:0] o_gx_q, o_gy_q;
  logic                    o_run_end_q, o_frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (b_go) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go) begin
      o_row_q       <= low_kind ? b_row_q : b_row_q - RowW'(1);
      o_col_q       <= edge_kind ? b_col_q : b_col_q - ColW'(1);
      o_gx_q        <= gx;
      o_gy_q        <= gy;
      o_run_end_q   <= b_last;
      o_frame_end_q <= sel[KindLowRight];
    end
  end

  assign out_valid_o = out_vld_q;
  assign row_o       = o_row_q;
  assign column_o    = o_col_q;
  assign grad_x_o    = o_gx_q;
  assign grad_y_o    = o_gy_q;
  assign run_end_o   = o_run_end_q;
  assign frame_end_o = o_frame_end_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_frame_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && o_frame_end_q |-> o_run_end_q)
    else $error("frame end result does not close its run");

  a_frame_end_not_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && o_frame_end_q |-> o_row_q != '0)
    else $error("frame end result on row zero");

  a_run_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !o_run_end_q |-> b_mask_q != '0)
    else $error("open run with no result left in the window stage");

  a_low_needs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q |-> (!a_mask_q[KindLowLeft] || a_mask_q[KindUpLeft]) &&
                (!a_mask_q[KindLowRight] || a_mask_q[KindUpRight]))
    else $error("last row result without its upper companion");

endmodule

/* bench/scharr_gradient_3x3_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scharr_gradient_3x3_tb
// Self-checking bench for the streaming 3x3 Scharr gradient block. A scoreboard
// keeps its own line stores, window and counters, predicts every gradient
// request from each accepted sample, and checks the output stream in order
// while both sides idle at random and the receiver holds off once for long.
// ----------------------------------------------------------------------------
module scharr_gradient_3x3_tb;
  import scharr_pkg::*;

  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned ColW         = $clog2(MaxWidth);
  localparam int unsigned GradW        = SampleW + 5;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned MaxReports   = 10;

  // index with no register behind it
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;
  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7fff;

  // window rows top to bottom, columns left to right
  localparam int WinTop   = 0;
  localparam int WinMid   = 1;
  localparam int WinBot   = 2;
  localparam int WinLeft  = 0;
  localparam int WinCtr   = 1;
  localparam int WinRight = 2;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    logic [RowW-1:0]         row;
    logic [ColW-1:0]         column;
    logic signed [GradW-1:0] grad_x;
    logic signed [GradW-1:0] grad_y;
    logic                    run_end;
    logic                    frame_end;
  } gradient_t;

  class gradient_scoreboard;
    sample_t               older_row [MaxWidth];
    sample_t               prev_row [MaxWidth];
    sample_t               win [3][3];
    logic [WidthRegW-1:0]  width_reg;
    logic [HeightRegW-1:0] height_reg;
    int unsigned           row_cnt;
    int unsigned           col_cnt;
    gradient_t             pending_grads [$];
    int unsigned           samples;
    int unsigned           checked;
    int unsigned           mismatches;
    int unsigned           writes;

    function new();
      foreach (older_row[i]) begin
        older_row[i] = '0;
        prev_row[i]  = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      width_reg  = WidthReset;
      height_reg = HeightReset;
      row_cnt    = 0;
      col_cnt    = 0;
      samples    = 0;
      checked    = 0;
      mismatches = 0;
      writes     = 0;
    endfunction

    function int unsigned frame_w();
      if (width_reg < 2) return 2;
      if (width_reg > MaxWidth) return MaxWidth;
      return width_reg;
    endfunction

    function int unsigned frame_h();
      if (height_reg < 2) return 2;
      if (height_reg > MaxHeight) return MaxHeight;
      return height_reg;
    endfunction

    function void note_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      writes++;
      case (idx)
        RegImageWidth:  width_reg = data[WidthRegW-1:0];
        RegImageHeight: height_reg = data[HeightRegW-1:0];
        default: return;
      endcase
      // restart the frame, keep stores and window
      row_cnt = 0;
      col_cnt = 0;
    endfunction

    function void add_grad(int unsigned r, int unsigned c, int t, int m, int b,
                           int l, int cc, int rt, logic last);
      gradient_t g;
      int gx;
      int gy;
      gx = 3 * (win[t][rt] - win[t][l]) + 10 * (win[m][rt] - win[m][l])
         + 3 * (win[b][rt] - win[b][l]);
      gy = 3 * (win[b][l] - win[t][l]) + 10 * (win[b][cc] - win[t][cc])
         + 3 * (win[b][rt] - win[t][rt]);
      g.row       = r[RowW-1:0];
      g.column    = c[ColW-1:0];
      g.grad_x    = gx[GradW-1:0];
      g.grad_y    = gy[GradW-1:0];
      g.run_end   = 1'b0;
      g.frame_end = last;
      pending_grads = {pending_grads, g};
    endfunction

    function void note_sample(sample_t s);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      int unsigned queued;
      int          top;
      int          left;
      int          i;
      sample_t     up2;
      sample_t     up1;
      bit          last_row;
      w      = frame_w();
      h      = frame_h();
      r      = row_cnt;
      c      = col_cnt;
      queued = pending_grads.size();
      samples++;
      up2          = older_row[c];
      up1          = prev_row[c];
      older_row[c] = up1;
      prev_row[c]  = s;
      for (i = 0; i < 3; i++) begin
        win[i][WinLeft] = win[i][WinCtr];
        win[i][WinCtr]  = win[i][WinRight];
      end
      win[WinTop][WinRight] = up2;
      win[WinMid][WinRight] = up1;
      win[WinBot][WinRight] = s;
      if (r >= 1) begin
        last_row = (r == h - 1);
        // mirror row -1 onto row 1, column -1 onto column 1
        top = (r == 1) ? WinBot : WinTop;
        if (c >= 1) begin
          left = (c == 1) ? WinRight : WinLeft;
          add_grad(r - 1, c - 1, top, WinMid, WinBot, left, WinCtr, WinRight, 1'b0);
          if (last_row) add_grad(r, c - 1, WinMid, WinBot, WinMid, left, WinCtr, WinRight, 1'b0);
        end
        if (c == w - 1) begin
          add_grad(r - 1, c, top, WinMid, WinBot, WinCtr, WinRight, WinCtr, 1'b0);
          if (last_row) add_grad(r, c, WinMid, WinBot, WinMid, WinCtr, WinRight, WinCtr, 1'b1);
        end
      end
      if (pending_grads.size() > queued) pending_grads[$].run_end = 1'b1;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_cnt = c;
      row_cnt = r;
    endfunction

    function void check_gradient(gradient_t got);
      gradient_t want;
      if (pending_grads.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("@%0t unexpected gradient: row %0d col %0d gx %0d gy %0d run %0b frame %0b",
                   $time, got.row, got.column, got.grad_x, got.grad_y, got.run_end,
                   got.frame_end);
        return;
      end
      want = pending_grads.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("@%0t gradient mismatch on request %0d", $time, checked);
          $display("  expected row %0d col %0d gx %0d gy %0d run %0b frame %0b",
                   want.row, want.column, want.grad_x, want.grad_y, want.run_end,
                   want.frame_end);
          $display("  actual   row %0d col %0d gx %0d gy %0d run %0b frame %0b",
                   got.row, got.column, got.grad_x, got.grad_y, got.run_end, got.frame_end);
        end
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [CfgIdxW-1:0]            cfg_index_i = '0;
  logic [CfgDataW-1:0]           cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  sample_t                       sample_i    = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [RowW-1:0]               row_o;
  logic [ColW-1:0]               column_o;
  logic signed [GradW-1:0]       grad_x_o;
  logic signed [GradW-1:0]       grad_y_o;
  logic                          run_end_o;
  logic                          frame_end_o;

  gradient_scoreboard sb;
  int unsigned        send_idle_pct = 8;
  int unsigned        recv_idle_pct = 62;
  bit                 hold_output   = 1'b0;

  scharr_gradient_3x3 #(
    .MAX_WIDTH  (MaxWidth),
    .SAMPLE_BITS(SampleW)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .row_o      (row_o),
    .column_o   (column_o),
    .grad_x_o   (grad_x_o),
    .grad_y_o   (grad_y_o),
    .run_end_o  (run_end_o),
    .frame_end_o(frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200_000;
    $display("FAIL");
    $finish;
  end

  // check the output before noting the input: no result leaves in the cycle
  // of the sample that causes it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_gradient({row_o, column_o, grad_x_o, grad_y_o, run_end_o, frame_end_o});
      if (in_valid_i && in_ready_o) sb.note_sample(sample_i);
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_output = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(7))
      0: return SampleMin;
      1: return SampleMax;
      2: return sample_t'(int'($urandom_range(16)) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(sample_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // drop valid, wait until every gradient is out, then let the pipe settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_grads.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.note_write(idx, data);
  endtask

  task automatic set_size(logic [CfgDataW-1:0] w_data, logic [CfgDataW-1:0] h_data);
    wait_idle();
    write_reg(RegImageWidth, w_data);
    write_reg(RegImageHeight, h_data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_sample(rand_sample());
  endtask

  task automatic random_frames(int unsigned quota);
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    sent = 0;
    while (sent < quota) begin
      case ($urandom_range(9))
        0: w = $urandom_range(1, 0);
        1: w = $urandom_range(12, 9);
        default: w = $urandom_range(6, 2);
      endcase
      h = ($urandom_range(9) == 0) ? $urandom_range(1, 0) : $urandom_range(4, 2);
      // upper data bits beyond the width field must be dropped
      set_size(CfgDataW'(w | ($urandom_range(3) << WidthRegW)), CfgDataW'(h));
      n = sb.frame_w() * sb.frame_h();
      case ($urandom_range(3))
        0: n = $urandom_range(n - 1, 1);
        1: n = n + sb.frame_w();
        default: ;
      endcase
      send_random(n);
      sent += n;
    end
  endtask

  initial begin : stimulus
    int unsigned i;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset size: a few samples into row 0
    send_random(6);

    // strongest horizontal gradient at the center pixel
    set_size(3, 3);
    for (i = 0; i < 3; i++) begin
      send_sample(SampleMin);
      send_sample((i == 1) ? -16'sd1 : 16'sd1);
      send_sample(SampleMax);
    end
    // strongest negative vertical gradient; a write to the spare index mid-frame
    for (i = 0; i < 9; i++) begin
      if (i == 4) begin
        wait_idle();
        write_reg(RegSpare, CfgDataW'($urandom));
        cfg_valid_i <= 1'b0;
      end
      send_sample((i < 3) ? SampleMax : (i < 6) ? 16'sd0 : SampleMin);
    end

    // width and height below the minimum act as 2 x 2
    set_size(13'h1801, 13'h0000);
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample(SampleMin);
    send_sample(SampleMax);

    random_frames(16);

    send_idle_pct = 62;
    recv_idle_pct = 8;
    random_frames(16);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // hold the output long enough for the block to back up into its input
    set_size(4, 3);
    hold_output = 1'b1;
    send_random(12);
    random_frames(16);

    wait_idle();
    $display("Checked %0d gradient results from %0d samples over %0d register writes.",
             sb.checked, sb.samples, sb.writes);
    $display("Frames ran from clamped 2x2 up to 12 wide, with gaps, stalls and a long hold.");
    if (sb.mismatches == 0 && sb.pending_grads.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
